### hw/rtl/frt_pkg.sv
`default_nettype none
package frt_pkg;

  // result status codes
  typedef enum logic [1:0] {
    StRejected  = 2'd0,
    StProgress  = 2'd1,
    StCompleted = 2'd2
  } status_e;

  // configuration register indexes
  localparam logic [1:0] CfgMaxFragCount = 2'd0;
  localparam logic [1:0] CfgMaxTotalBytes = 2'd1;
  localparam logic [1:0] CfgTimeoutMs = 2'd2;

  localparam logic [31:0] DefaultTimeoutMs = 32'd60000;
  localparam logic [23:0] BytesMax = 24'hFF_FFFF;

  // one fragment header
  typedef struct packed {
    logic [63:0] snapshot_id;
    logic [15:0] chunk_index;
    logic [15:0] chunk_count;
    logic [15:0] payload_len;
    logic [31:0] now_ms;
  } item_t;

  // scalar part of the assembly context
  typedef struct packed {
    logic        active;
    logic [63:0] snapshot;
    logic [15:0] count;
    logic [31:0] start_time;
    logic [23:0] byte_total;
    logic [15:0] rcvd_count;
  } asm_t;

  // configuration registers
  typedef struct packed {
    logic [15:0] max_frag_count;
    logic [23:0] max_total_bytes;
    logic [31:0] timeout_ms;
  } cfg_t;

  // decision of one step towards the bitmap and counter
  typedef struct packed {
    logic    clear_map;
    logic    mark;
    logic    complete;
    status_e status;
  } step_ctl_t;

endpackage
`default_nettype wire

### hw/rtl/frt_step.sv
`default_nettype none
module frt_step #(
  parameter int unsigned MAX_CHUNKS = 256
) (
  input  frt_pkg::item_t     item_i,
  input  frt_pkg::asm_t      cur_i,
  input  frt_pkg::cfg_t      cfg_i,
  input  logic               map_hit_i,
  output frt_pkg::asm_t      nxt_o,
  output frt_pkg::step_ctl_t ctl_o
);

  logic        hdr_bad;
  logic        new_asm;
  logic [31:0] limit;
  logic [31:0] start_eff;
  logic [31:0] elapsed;
  logic        timed_out;
  logic        dup;
  logic [23:0] bytes_eff;
  logic [24:0] sum;
  logic        over;
  logic [15:0] rcvd_eff;
  logic [15:0] rcvd_inc;
  logic        done;

  always_comb begin
    hdr_bad = (item_i.chunk_count == 16'd0)
           || (item_i.chunk_index >= item_i.chunk_count)
           || ((cfg_i.max_frag_count != 16'd0)
               && (item_i.chunk_count > cfg_i.max_frag_count))
           || ({1'b0, item_i.chunk_count} > 17'(MAX_CHUNKS));

    new_asm = !cur_i.active || (cur_i.snapshot != item_i.snapshot_id)
           || (cur_i.count != item_i.chunk_count);

    limit     = (cfg_i.timeout_ms != 32'd0) ? cfg_i.timeout_ms : frt_pkg::DefaultTimeoutMs;
    start_eff = new_asm ? item_i.now_ms : cur_i.start_time;
    elapsed   = item_i.now_ms - start_eff;
    timed_out = elapsed > limit;

    // a fresh assembly has an empty bitmap
    dup = !new_asm && map_hit_i;

    bytes_eff = new_asm ? 24'd0 : cur_i.byte_total;
    sum       = {1'b0, bytes_eff} + 25'(item_i.payload_len);
    over      = (cfg_i.max_total_bytes != 24'd0) && (sum > {1'b0, cfg_i.max_total_bytes});

    rcvd_eff = new_asm ? 16'd0 : cur_i.rcvd_count;
    rcvd_inc = rcvd_eff + 16'd1;
    done     = !(rcvd_inc < item_i.chunk_count);

    nxt_o = cur_i;
    ctl_o = '{clear_map: 1'b0, mark: 1'b0, complete: 1'b0, status: frt_pkg::StRejected};

    if (!hdr_bad) begin
      if (new_asm) begin
        ctl_o.clear_map  = 1'b1;
        nxt_o.active     = 1'b1;
        nxt_o.snapshot   = item_i.snapshot_id;
        nxt_o.count      = item_i.chunk_count;
        nxt_o.start_time = item_i.now_ms;
        nxt_o.byte_total = 24'd0;
        nxt_o.rcvd_count = 16'd0;
      end
      priority if (timed_out) begin
        nxt_o.active = 1'b0;
      end else if (dup) begin
        ctl_o.status = frt_pkg::StProgress;
      end else if (over) begin
        nxt_o.active = 1'b0;
      end else begin
        ctl_o.mark       = 1'b1;
        nxt_o.byte_total = sum[24] ? frt_pkg::BytesMax : sum[23:0];
        nxt_o.rcvd_count = rcvd_inc;
        if (done) begin
          ctl_o.complete = 1'b1;
          ctl_o.status   = frt_pkg::StCompleted;
          nxt_o.active   = 1'b0;
        end else begin
          ctl_o.status = frt_pkg::StProgress;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/fragment_reassembly_tracker_core.sv
// fragment reassembly tracker
// tracks one assembly of chunked snapshots from fragment headers; payload
// bytes are not stored, only their lengths are summed
// input channel: in_valid_i / in_ready_o with one header per item
// output channel: out_valid_o / out_ready_i, one status item per header plus
// the running count of completed assemblies after that header
// configuration: cfg_we_i writes register cfg_index_i (0 max chunk count,
// 1 max byte total, 2 timeout in ms); the user makes writes only while the
// block is idle, which the block itself does not enforce
// throughput: one item per cycle while results are taken; the whole
// check/update sits between the input register and the result register, and
// the 256-entry chunk bitmap is a row of flops cleared when an assembly starts
// stall: while a result waits, the input register still takes one more item;
// the block then holds ready low until the result is taken
// reset: all configuration zero (no limits, default timeout of 60000 ms),
// no active assembly, bitmap cleared, completion count zero
`default_nettype none
module fragment_reassembly_tracker_core #(
  parameter int unsigned MAX_CHUNKS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // header items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] snapshot_id_i,
  input  logic [15:0] chunk_index_i,
  input  logic [15:0] chunk_count_i,
  input  logic [15:0] payload_len_i,
  input  logic [31:0] now_ms_i,
  // status items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] completed_total_o
);

  localparam int unsigned IdxW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

  frt_pkg::cfg_t cfg_q;

  // input register
  logic           s1_valid_q;
  frt_pkg::item_t s1_item_q;

  // result register
  logic             out_valid_q;
  frt_pkg::status_e status_q;
  logic [31:0]      total_q;

  // assembly context
  frt_pkg::asm_t          asm_q, asm_d;
  logic [MAX_CHUNKS-1:0]  map_q, map_d;
  logic [31:0]            completions_q, completions_d;

  frt_pkg::step_ctl_t ctl;
  logic               advance;
  logic               in_take;
  logic [IdxW-1:0]    idx;
  logic               map_hit;

  function automatic logic [IdxW-1:0] chunk_idx_trim(input logic [15:0] v);
    return v[IdxW-1:0];
  endfunction

  // the stage moves whenever the result register is free or being emptied
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  // index is only used once the header passed the range check
  assign idx     = chunk_idx_trim(s1_item_q.chunk_index);
  assign map_hit = map_q[idx];

  frt_step #(
    .MAX_CHUNKS(MAX_CHUNKS)
  ) u_step (
    .item_i   (s1_item_q),
    .cur_i    (asm_q),
    .cfg_i    (cfg_q),
    .map_hit_i(map_hit),
    .nxt_o    (asm_d),
    .ctl_o    (ctl)
  );

  always_comb begin
    map_d = map_q;
    if (ctl.clear_map) begin
      map_d = '0;
    end
    if (ctl.mark) begin
      map_d[idx] = 1'b1;
    end
    completions_d = completions_q + {31'd0, ctl.complete};
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        frt_pkg::CfgMaxFragCount:  cfg_q.max_frag_count  <= cfg_data_i[15:0];
        frt_pkg::CfgMaxTotalBytes: cfg_q.max_total_bytes <= cfg_data_i[23:0];
        frt_pkg::CfgTimeoutMs:     cfg_q.timeout_ms      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= '{snapshot_id: snapshot_id_i, chunk_index: chunk_index_i,
                     chunk_count: chunk_count_i, payload_len: payload_len_i,
                     now_ms: now_ms_i};
    end
    if (advance) begin
      status_q <= ctl.status;
      total_q  <= completions_d;
    end
  end

  // assembly state advances with each evaluated header
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asm_q         <= '0;
      map_q         <= '0;
      completions_q <= '0;
    end else if (advance) begin
      asm_q         <= asm_d;
      map_q         <= map_d;
      completions_q <= completions_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign completed_total_o = total_q;

endmodule
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int unsigned MaxChunks = 256;
  localparam int StallLimit = 2000;
  localparam int SegItems = 100;
  localparam logic [1:0] CfgUnused = 2'd3;

  typedef struct packed {
    frt_pkg::status_e status;
    logic [31:0]      total;
  } verdict_t;

  typedef enum logic {RowHeader, RowConfig} row_kind_e;

  typedef struct packed {
    row_kind_e      kind;
    frt_pkg::item_t hdr;
    logic [1:0]     reg_idx;
    logic [31:0]    reg_data;
    logic           typed;
    verdict_t       want;
  } plan_row_t;

  // dut side
  logic           clk_i = 1'b0;
  logic           rst_n_r = 1'b0;
  logic           cfg_we_r = 1'b0;
  logic [1:0]     cfg_index_r = '0;
  logic [31:0]    cfg_data_r = '0;
  logic           in_valid_r = 1'b0;
  logic           in_ready_o;
  frt_pkg::item_t hdr_r = '0;
  logic           out_valid_o;
  logic           out_ready_r = 1'b0;
  logic [1:0]     status_o;
  logic [31:0]    completed_total_o;

  // predictor copy of the registers and assembly context
  logic [15:0]          lim_count = '0;
  logic [23:0]          lim_bytes = '0;
  logic [31:0]          lim_time = '0;
  logic                 asm_live = 1'b0;
  logic [63:0]          asm_snap = '0;
  logic [15:0]          asm_cnt = '0;
  logic [31:0]          asm_start = '0;
  logic [23:0]          asm_bytes = '0;
  logic [15:0]          asm_rcvd = '0;
  logic [MaxChunks-1:0] chunk_seen = '0;
  logic [31:0]          done_count = '0;

  verdict_t  awaited_verdicts[$];
  verdict_t  head_verdict;
  plan_row_t plan[$];
  int        mismatches = 0;
  int        sent_items = 0;
  int        stall_cycles = 0;
  int        send_idle = 28;
  int        recv_idle = 51;
  logic [31:0] clock_ms = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fragment_reassembly_tracker_core #(
    .MAX_CHUNKS(MaxChunks)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_n_r),
    .cfg_we_i         (cfg_we_r),
    .cfg_index_i      (cfg_index_r),
    .cfg_data_i       (cfg_data_r),
    .in_valid_i       (in_valid_r),
    .in_ready_o       (in_ready_o),
    .snapshot_id_i    (hdr_r.snapshot_id),
    .chunk_index_i    (hdr_r.chunk_index),
    .chunk_count_i    (hdr_r.chunk_count),
    .payload_len_i    (hdr_r.payload_len),
    .now_ms_i         (hdr_r.now_ms),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_r),
    .status_o         (status_o),
    .completed_total_o(completed_total_o)
  );

  // expected status of one header, advancing the predicted assembly context
  function automatic verdict_t track_fragment(input frt_pkg::item_t h);
    logic [31:0] window;
    logic [31:0] elapsed;
    logic [24:0] sum;
    verdict_t    v;
    v.status = frt_pkg::StRejected;
    if (h.chunk_count == 16'd0 || h.chunk_index >= h.chunk_count ||
        (lim_count != 16'd0 && h.chunk_count > lim_count) ||
        h.chunk_count > MaxChunks) begin
      // header refused, context untouched
    end else begin
      if (!asm_live || asm_snap != h.snapshot_id || asm_cnt != h.chunk_count) begin
        asm_live = 1'b1;
        asm_snap = h.snapshot_id;
        asm_cnt = h.chunk_count;
        asm_start = h.now_ms;
        asm_bytes = '0;
        asm_rcvd = '0;
        chunk_seen = '0;
      end
      window = (lim_time != 32'd0) ? lim_time : frt_pkg::DefaultTimeoutMs;
      elapsed = h.now_ms - asm_start;
      if (elapsed > window) begin
        asm_live = 1'b0;
      end else if (chunk_seen[h.chunk_index[7:0]]) begin
        v.status = frt_pkg::StProgress;
      end else begin
        sum = {1'b0, asm_bytes} + {9'b0, h.payload_len};
        if (lim_bytes != 24'd0 && sum > {1'b0, lim_bytes}) begin
          asm_live = 1'b0;
        end else begin
          if (sum > {1'b0, frt_pkg::BytesMax}) sum = {1'b0, frt_pkg::BytesMax};
          chunk_seen[h.chunk_index[7:0]] = 1'b1;
          asm_bytes = sum[23:0];
          asm_rcvd = asm_rcvd + 16'd1;
          if (asm_rcvd < asm_cnt) begin
            v.status = frt_pkg::StProgress;
          end else begin
            done_count = done_count + 32'd1;
            asm_live = 1'b0;
            v.status = frt_pkg::StCompleted;
          end
        end
      end
    end
    v.total = done_count;
    return v;
  endfunction

  function automatic plan_row_t header_row(input logic [63:0] snap, input logic [15:0] idx,
                                           input logic [15:0] cnt, input logic [15:0] len,
                                           input logic [31:0] now);
    plan_row_t r;
    r = '0;
    r.kind = RowHeader;
    r.hdr.snapshot_id = snap;
    r.hdr.chunk_index = idx;
    r.hdr.chunk_count = cnt;
    r.hdr.payload_len = len;
    r.hdr.now_ms = now;
    return r;
  endfunction

  function automatic plan_row_t checked_row(input logic [63:0] snap, input logic [15:0] idx,
                                            input logic [15:0] cnt, input logic [15:0] len,
                                            input logic [31:0] now,
                                            input frt_pkg::status_e st,
                                            input logic [31:0] total);
    plan_row_t r;
    r = header_row(snap, idx, cnt, len, now);
    r.typed = 1'b1;
    r.want.status = st;
    r.want.total = total;
    return r;
  endfunction

  function automatic plan_row_t config_row(input logic [1:0] idx, input logic [31:0] data);
    plan_row_t r;
    r = '0;
    r.kind = RowConfig;
    r.reg_idx = idx;
    r.reg_data = data;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  // one header item; valid is only lowered when a gap is wanted
  task automatic send_header(input frt_pkg::item_t h, input logic typed,
                             input verdict_t want);
    verdict_t v;
    if ($urandom_range(99) < send_idle) begin
      in_valid_r <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid_r <= 1'b1;
    hdr_r <= h;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    v = track_fragment(h);
    awaited_verdicts.push_back(typed ? want : v);
    sent_items++;
  endtask

  // let every awaited status item come back before touching the registers
  task automatic drain_results();
    in_valid_r <= 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we_r <= 1'b1;
    cfg_index_r <= idx;
    cfg_data_r <= data;
    @(posedge clk_i);
    cfg_we_r <= 1'b0;
    case (idx)
      frt_pkg::CfgMaxFragCount:  lim_count = data[15:0];
      frt_pkg::CfgMaxTotalBytes: lim_bytes = data[23:0];
      frt_pkg::CfgTimeoutMs:     lim_time = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic program_limits(input logic [31:0] cnt_lim, input logic [31:0] byte_lim,
                                input logic [31:0] time_lim);
    drain_results();
    write_reg(frt_pkg::CfgMaxFragCount, cnt_lim);
    write_reg(frt_pkg::CfgMaxTotalBytes, byte_lim);
    write_reg(frt_pkg::CfgTimeoutMs, time_lim);
  endtask

  // one snapshot sent chunk by chunk in shuffled order, with duplicates,
  // stray headers and the odd sequence cut short
  task automatic send_assembly();
    logic [63:0]    snap;
    logic [15:0]    cnt;
    frt_pkg::item_t h;
    int             order[MaxChunks];
    int             n, k, j, tmp, r;
    logic           sane;
    logic           broken;
    snap = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 70) cnt = 16'($urandom_range(1, 8));
    else if (r < 88) cnt = 16'($urandom_range(9, 40));
    else if (r < 90) cnt = 16'($urandom_range(200, MaxChunks));
    else if (r < 95) cnt = 16'($urandom);
    else cnt = $urandom_range(1) ? 16'd0 : 16'(MaxChunks + 1);
    sane = (cnt != 16'd0 && cnt <= MaxChunks);
    n = sane ? int'(cnt) : $urandom_range(1, 3);
    if (sane) begin
      for (k = 0; k < n; k++) order[k] = k;
      for (k = n - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        tmp = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
    end
    broken = 1'b0;
    for (k = 0; k < n && !broken; k++) begin
      clock_ms = clock_ms + (($urandom_range(49) == 0) ? $urandom : $urandom_range(0, 40));
      h.snapshot_id = snap;
      h.chunk_count = cnt;
      h.chunk_index = sane ? 16'(order[k]) : 16'($urandom);
      h.payload_len = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
      h.now_ms = clock_ms;
      send_header(h, 1'b0, '0);
      if (sane && $urandom_range(9) == 0) begin
        h.chunk_index = 16'(order[$urandom_range(0, k)]);
        send_header(h, 1'b0, '0);
      end
      if ($urandom_range(11) == 0) begin
        // stray header: foreign snapshot, or same snapshot with another count
        if ($urandom_range(1)) begin
          h.snapshot_id = {$urandom, $urandom};
          h.chunk_count = 16'($urandom);
          h.chunk_index = 16'($urandom);
          h.now_ms = $urandom;
        end else begin
          h.chunk_count = cnt + 16'd1;
        end
        h.payload_len = 16'($urandom);
        send_header(h, 1'b0, '0);
      end
      if ($urandom_range(59) == 0) broken = 1'b1;
    end
  endtask

  // status items: compare against the oldest expectation, then pick ready
  always @(posedge clk_i) begin
    if (rst_n_r && out_valid_o && out_ready_r) begin
      if (awaited_verdicts.size() == 0) begin
        flag_mismatch($sformatf("status item with nothing awaited: status %0d total %0d",
                                status_o, completed_total_o));
      end else begin
        head_verdict = awaited_verdicts.pop_front();
        if (status_o !== head_verdict.status)
          flag_mismatch($sformatf("status: expected %0d, got %0d",
                                  head_verdict.status, status_o));
        if (completed_total_o !== head_verdict.total)
          flag_mismatch($sformatf("completed_total: expected %0d, got %0d",
                                  head_verdict.total, completed_total_o));
      end
    end
    out_ready_r <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog on cycles without any item moving
  always @(posedge clk_i) begin
    if (rst_n_r) begin
      if ((in_valid_r && in_ready_o) || (out_valid_o && out_ready_r)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("fragment_reassembly_tracker_core verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int seg;
    int goal;
    // directed table, registers at their reset values to start with
    plan.push_back(checked_row(64'd0, 16'd0, 16'd0, 16'd0, 32'd0,
                               frt_pkg::StRejected, 32'd0));
    plan.push_back(checked_row(64'd1, 16'd5, 16'd5, 16'd10, 32'd0,
                               frt_pkg::StRejected, 32'd0));
    plan.push_back(checked_row(64'd2, 16'd0, 16'(MaxChunks + 1), 16'd0, 32'd0,
                               frt_pkg::StRejected, 32'd0));
    plan.push_back(checked_row('1, 16'hFFFE, 16'hFFFF, 16'hFFFF, '1,
                               frt_pkg::StRejected, 32'd0));
    // single-chunk snapshots complete at once
    plan.push_back(checked_row(64'd0, 16'd0, 16'd1, 16'd0, 32'd0,
                               frt_pkg::StCompleted, 32'd1));
    plan.push_back(checked_row('1, 16'd0, 16'd1, 16'hFFFF, '1,
                               frt_pkg::StCompleted, 32'd2));
    // largest assembly, last chunk first, then a duplicate of it
    plan.push_back(checked_row(64'h0123_4567_89AB_CDEF, 16'd255, 16'd256, 16'hFFFF, 32'd100,
                               frt_pkg::StProgress, 32'd2));
    plan.push_back(checked_row(64'h0123_4567_89AB_CDEF, 16'd255, 16'd256, 16'hFFFF, 32'd150,
                               frt_pkg::StProgress, 32'd2));
    plan.push_back(header_row(64'h0123_4567_89AB_CDEF, 16'd0, 16'd256, 16'd0, 32'd200));
    // elapsed time across the wrap of the millisecond counter
    plan.push_back(header_row(64'h5A5A_A5A5_0F0F_F0F0, 16'd0, 16'd3, 16'd1, 32'hFFFF_FF00));
    plan.push_back(header_row(64'h5A5A_A5A5_0F0F_F0F0, 16'd1, 16'd3, 16'd1, 32'h0000_0100));
    plan.push_back(checked_row(64'h5A5A_A5A5_0F0F_F0F0, 16'd2, 16'd3, 16'd1, 32'd59745,
                               frt_pkg::StRejected, 32'd2));
    // elapsed exactly at the default lifetime still counts
    plan.push_back(header_row(64'h8000_0000_0000_0001, 16'd0, 16'd2, 16'd7, 32'd1000));
    plan.push_back(header_row(64'h8000_0000_0000_0001, 16'd1, 16'd2, 16'd7, 32'd61000));
    // byte limit
    plan.push_back(config_row(frt_pkg::CfgMaxTotalBytes, 32'd100));
    plan.push_back(header_row(64'hD, 16'd0, 16'd3, 16'd60, 32'd5));
    plan.push_back(header_row(64'hD, 16'd1, 16'd3, 16'd41, 32'd6));
    plan.push_back(header_row(64'hD, 16'd1, 16'd3, 16'd40, 32'd7));
    // chunk count limit, upper bits of the write dropped
    plan.push_back(config_row(frt_pkg::CfgMaxFragCount, 32'hFFFF_0004));
    plan.push_back(checked_row(64'hE, 16'd0, 16'd5, 16'd0, 32'd10,
                               frt_pkg::StRejected, 32'd3));
    plan.push_back(header_row(64'hE, 16'd3, 16'd4, 16'd0, 32'd10));
    // short lifetime
    plan.push_back(config_row(frt_pkg::CfgTimeoutMs, 32'd10));
    plan.push_back(header_row(64'hF, 16'd0, 16'd2, 16'd0, 32'd0));
    plan.push_back(header_row(64'hF, 16'd1, 16'd2, 16'd0, 32'd11));
    // unused index is ignored, then every register at its top value
    plan.push_back(config_row(CfgUnused, '1));
    plan.push_back(config_row(frt_pkg::CfgMaxFragCount, '1));
    plan.push_back(config_row(frt_pkg::CfgMaxTotalBytes, '1));
    plan.push_back(config_row(frt_pkg::CfgTimeoutMs, '1));
    plan.push_back(header_row(64'h6, 16'd0, 16'd2, 16'hFFFF, 32'd0));
    plan.push_back(header_row(64'h6, 16'd1, 16'd2, 16'hFFFF, '1));

    repeat (2) @(posedge clk_i);
    rst_n_r <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == RowConfig) begin
        drain_results();
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        send_header(plan[i].hdr, plan[i].typed, plan[i].want);
      end
    end

    // random part: two register settings per idling pattern
    for (seg = 0; seg < 6; seg++) begin
      case (seg)
        0: program_limits(32'd0, 32'd0, 32'd0);
        2: program_limits('1, '1, '1);
        3: program_limits(32'd1, 32'd1, 32'd1);
        5: program_limits(32'd0, 32'd0, 32'd0);
        default: program_limits($urandom_range(1, 12), $urandom_range(200, 400000),
                                $urandom_range(50, 3000));
      endcase
      case (seg / 2)
        0: begin send_idle = 28; recv_idle = 51; end
        1: begin send_idle = 51; recv_idle = 28; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      goal = sent_items + SegItems;
      while (sent_items < goal) send_assembly();
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && awaited_verdicts.size() == 0) begin
      $display("fragment_reassembly_tracker_core verification clean");
    end else begin
      $display("fragment_reassembly_tracker_core verification failed");
    end
    $finish;
  end

endmodule
